// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property: holds at every clock edge outside reset.
`define URBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent must hold at the next clock edge.
`define URBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/urbp_pkg.sv
// Shared constants, request codes and a helper function of the UART ring buffer pair.
`default_nettype none

package urbp_pkg;

    // Ring depths; each ring holds at most depth minus one bytes.
    localparam int RX_DEPTH = 32;
    localparam int TX_DEPTH = 32;

    // Pointer widths and wrap masks.
    localparam int RX_PW = $clog2(RX_DEPTH);
    localparam int TX_PW = $clog2(TX_DEPTH);
    localparam logic [RX_PW-1:0] RX_MASK = RX_PW'(RX_DEPTH - 1);
    localparam logic [TX_PW-1:0] TX_MASK = TX_PW'(TX_DEPTH - 1);

    // Fixed field widths.
    localparam int BYTE_W  = 8;
    localparam int ERR_W   = 3;
    localparam int COUNT_W = 5;

    // Last-error code for a byte dropped on a full receive ring.
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'b100;

    // Request codes; code 7 is unused and answers like a count request.
    typedef enum logic [2:0] {
        REQ_LINE_RX  = 3'd0,
        REQ_GET      = 3'd1,
        REQ_PEEK     = 3'd2,
        REQ_TX_WRITE = 3'd3,
        REQ_TX_READY = 3'd4,
        REQ_FLUSH    = 3'd5,
        REQ_COUNT    = 3'd6
    } req_e_t;

    // Number of bytes waiting in the receive ring, reduced to the count field.
    function automatic logic [COUNT_W-1:0] rx_fill(input logic [RX_PW-1:0] head,
                                                   input logic [RX_PW-1:0] tail);
        logic [RX_PW:0]   sum;
        logic [RX_PW-1:0] masked;
        sum    = (RX_PW + 1)'(RX_DEPTH) + {1'b0, head} - {1'b0, tail};
        masked = sum[RX_PW-1:0] & RX_MASK;
        return COUNT_W'(masked);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/urbp_ram.sv
// Generic single-write, single-read RAM with registered read and write-to-read bypass.
`default_nettype none

module urbp_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr_w;

    assign rd_addr_w = rd_addr;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a write to the same entry in the same cycle is passed through.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr_w))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr_w];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/uart_ring_buffer_pair.sv
// UART receive and transmit ring buffer pair: top level.
// Timing: an accepted request goes to the request register, then to the answer register,
// which offers it until it is taken. Throughput: one request per cycle while not stalled,
// set by the single compute stage between the request register and the answer register;
// the store read for a request runs as it is accepted.
// Reset: rst_n clears pointers, last error, transmit enable and the request and answer valid flags at once.
`default_nettype none

module uart_ring_buffer_pair (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [2:0]                          req_type,
    input  logic [urbp_pkg::BYTE_W-1:0]         byte_in,
    input  logic                                frame_err_in,
    input  logic                                overrun_err_in,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [urbp_pkg::BYTE_W-1:0]         byte_out,
    output logic                                byte_valid,
    output logic [urbp_pkg::ERR_W-1:0]          error_flags,
    output logic [urbp_pkg::COUNT_W-1:0]        rx_count,
    output logic                                tx_refused,
    output logic                                tx_request
);

    localparam int RX_PW  = urbp_pkg::RX_PW;
    localparam int TX_PW  = urbp_pkg::TX_PW;
    localparam int BYTE_W = urbp_pkg::BYTE_W;
    localparam int ERR_W  = urbp_pkg::ERR_W;

    // Request register.
    logic                 s1_valid_reg, s1_valid_next;
    urbp_pkg::req_e_t     s1_type_reg;
    logic [BYTE_W-1:0]    s1_byte_reg;
    logic                 s1_fe_reg;
    logic                 s1_ov_reg;

    // Ring state.
    logic [RX_PW-1:0]     rx_head_reg, rx_head_next;
    logic [RX_PW-1:0]     rx_tail_reg, rx_tail_next;
    logic [TX_PW-1:0]     tx_head_reg, tx_head_next;
    logic [TX_PW-1:0]     tx_tail_reg, tx_tail_next;
    logic [ERR_W-1:0]     last_error_reg, last_error_next;
    logic                 tx_enable_reg, tx_enable_next;

    // Answer register.
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [BYTE_W-1:0]             byte_out_reg;
    logic                          byte_valid_reg;
    logic [ERR_W-1:0]              error_flags_reg;
    logic [urbp_pkg::COUNT_W-1:0]  rx_count_reg;
    logic                          tx_refused_reg;
    logic                          tx_request_reg;

    // Step results of the request in the register.
    logic [RX_PW-1:0]     rx_head_step, rx_tail_step;
    logic [TX_PW-1:0]     tx_head_step, tx_tail_step;
    logic [ERR_W-1:0]     err_step;
    logic                 en_step;
    logic [BYTE_W-1:0]    byte_step;
    logic                 valid_step;
    logic                 refused_step;
    logic                 rx_we, tx_we;

    // Ring status.
    logic [RX_PW-1:0]     rx_head_inc, rx_tail_inc;
    logic [TX_PW-1:0]     tx_head_inc, tx_tail_inc;
    logic                 rx_full, rx_empty, tx_full, tx_empty;

    // Store ports.
    logic [BYTE_W-1:0]    rx_rd_data, tx_rd_data;
    logic [RX_PW-1:0]     rx_rd_addr;
    logic [TX_PW-1:0]     tx_rd_addr;

    logic                 accept;
    logic                 advance;

    // Handshake: the request register moves on when the answer register is free or taken.
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && rsp_stall);

    // Wrapped successor pointers and ring status.
    assign rx_head_inc = RX_PW'(rx_head_reg + RX_PW'(1)) & urbp_pkg::RX_MASK;
    assign rx_tail_inc = RX_PW'(rx_tail_reg + RX_PW'(1)) & urbp_pkg::RX_MASK;
    assign tx_head_inc = TX_PW'(tx_head_reg + TX_PW'(1)) & urbp_pkg::TX_MASK;
    assign tx_tail_inc = TX_PW'(tx_tail_reg + TX_PW'(1)) & urbp_pkg::TX_MASK;
    assign rx_full  = (rx_head_inc == rx_tail_reg);
    assign rx_empty = (rx_head_reg == rx_tail_reg);
    assign tx_full  = (tx_head_inc == tx_tail_reg);
    assign tx_empty = (tx_head_reg == tx_tail_reg);

    // Request decode and state step.
    always_comb
    begin
        rx_head_step = rx_head_reg;
        rx_tail_step = rx_tail_reg;
        tx_head_step = tx_head_reg;
        tx_tail_step = tx_tail_reg;
        err_step     = last_error_reg;
        en_step      = tx_enable_reg;
        byte_step    = '0;
        valid_step   = 1'b0;
        refused_step = 1'b0;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        unique case (s1_type_reg)
            urbp_pkg::REQ_LINE_RX:
            begin
                if (!rx_full)
                begin
                    rx_we        = 1'b1;
                    rx_head_step = rx_head_inc;
                    err_step     = {1'b0, s1_ov_reg, s1_fe_reg};
                end
                else
                begin
                    err_step = urbp_pkg::ERR_OVERFLOW;
                end
            end
            urbp_pkg::REQ_GET, urbp_pkg::REQ_PEEK:
            begin
                if (!rx_empty)
                begin
                    byte_step  = rx_rd_data;
                    valid_step = 1'b1;
                    if (s1_type_reg == urbp_pkg::REQ_GET)
                    begin
                        rx_tail_step = rx_tail_inc;
                    end
                end
            end
            urbp_pkg::REQ_TX_WRITE:
            begin
                if (tx_full)
                begin
                    refused_step = 1'b1;
                end
                else
                begin
                    tx_we        = 1'b1;
                    tx_head_step = tx_head_inc;
                    en_step      = 1'b1;
                end
            end
            urbp_pkg::REQ_TX_READY:
            begin
                if (!tx_empty)
                begin
                    tx_tail_step = tx_tail_inc;
                    byte_step    = tx_rd_data;
                    valid_step   = 1'b1;
                end
                else
                begin
                    en_step = 1'b0;
                end
            end
            urbp_pkg::REQ_FLUSH:
            begin
                rx_head_step = rx_tail_reg;
            end
            default:
            begin
                // Count and the unused code only report status.
            end
        endcase
    end

    // State commits only when the request moves into the answer register.
    assign rx_head_next    = advance ? rx_head_step : rx_head_reg;
    assign rx_tail_next    = advance ? rx_tail_step : rx_tail_reg;
    assign tx_head_next    = advance ? tx_head_step : tx_head_reg;
    assign tx_tail_next    = advance ? tx_tail_step : tx_tail_reg;
    assign last_error_next = advance ? err_step : last_error_reg;
    assign tx_enable_next  = advance ? en_step : tx_enable_reg;

    // The next request reads the entry after the tail as it stands after this step.
    assign rx_rd_addr = RX_PW'(rx_tail_next + RX_PW'(1)) & urbp_pkg::RX_MASK;
    assign tx_rd_addr = TX_PW'(tx_tail_next + TX_PW'(1)) & urbp_pkg::TX_MASK;

    // Receive byte store.
    urbp_ram #(
        .DEPTH (urbp_pkg::RX_DEPTH),
        .WIDTH (BYTE_W)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (advance && rx_we),
        .wr_addr (rx_head_inc),
        .wr_data (s1_byte_reg),
        .rd_en   (accept),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    // Transmit byte store.
    urbp_ram #(
        .DEPTH (urbp_pkg::TX_DEPTH),
        .WIDTH (BYTE_W)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (advance && tx_we),
        .wr_addr (tx_head_inc),
        .wr_data (s1_byte_reg),
        .rd_en   (accept),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            last_error_reg <= '0;
            tx_enable_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            last_error_reg <= last_error_next;
            tx_enable_reg  <= tx_enable_next;
        end
    end

    // Request payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_type_reg <= urbp_pkg::req_e_t'(req_type);
            s1_byte_reg <= byte_in;
            s1_fe_reg   <= frame_err_in;
            s1_ov_reg   <= overrun_err_in;
        end
    end

    // Answer payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_out_reg    <= byte_step;
            byte_valid_reg  <= valid_step;
            error_flags_reg <= err_step;
            rx_count_reg    <= urbp_pkg::rx_fill(rx_head_step, rx_tail_step);
            tx_refused_reg  <= refused_step;
            tx_request_reg  <= en_step;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign byte_out    = byte_out_reg;
    assign byte_valid  = byte_valid_reg;
    assign error_flags = error_flags_reg;
    assign rx_count    = rx_count_reg;
    assign tx_refused  = tx_refused_reg;
    assign tx_request  = tx_request_reg;

endmodule

`default_nettype wire

// File: hw/rtl/urbp_checker.sv
// Port-level checker of the UART ring buffer pair and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module urbp_port_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  logic [urbp_pkg::BYTE_W-1:0]         byte_out,
    input  logic                                byte_valid,
    input  logic [urbp_pkg::COUNT_W-1:0]        rx_count,
    input  logic                                tx_refused,
    input  logic                                tx_request
);

    // A stalled answer stays offered with the same byte.
    `URBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
        rsp_valid && $stable(byte_out), "answer changed while stalled")

    // An answer without data carries a zero byte.
    `URBP_ASSERT(a_no_data_zero, !(rsp_valid && !byte_valid) || (byte_out == '0),
        "byte_out not zero without data")

    // A refused write means the ring holds bytes, so transmit requests stay enabled.
    `URBP_ASSERT(a_refused_enabled,
        !(rsp_valid && tx_refused) || (tx_request && !byte_valid),
        "refused write without transmit request")

    // The receive count never reaches the ring depth.
    `URBP_ASSERT(a_count_bound,
        !rsp_valid || (int'(rx_count) <= urbp_pkg::RX_DEPTH - 1),
        "receive count out of range")

endmodule

bind uart_ring_buffer_pair urbp_port_checker u_checker (.*);

`default_nettype wire
